[rtl/gctb_pkg.sv]
// ----------------------------------------------------------------------------
// gctb_pkg
// Shared types and constants for the gamma curve table builder.
// ----------------------------------------------------------------------------
package gctb_pkg;

  localparam int LINEAR_MAX_DEF = 4095;
  localparam int KNOTS          = 257;
  localparam int KNOT_AW        = 9;
  localparam int GAMMA_TOP      = 255;
  localparam int CMDQ_DEPTH     = 4;
  localparam int CMDQ_AW        = 2;

  localparam logic [KNOT_AW-1:0] LAST_KNOT = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [KNOT_AW-1:0] idx;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [11:0]        pixel;
  } cmd_t;

  // queue head offered by the front part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_YMAX,
    ST_MULX,
    ST_STX,
    ST_DIVX,
    ST_MULY,
    ST_STY,
    ST_DIVY,
    ST_SEGSET,
    ST_PIX,
    ST_WDIV,
    ST_WMUL,
    ST_WADD
  } back_state_e;

endpackage

[rtl/gctb_if.sv]
// ----------------------------------------------------------------------------
// gctb_if
// Valid/ready channels for requests and lookup results.
// ----------------------------------------------------------------------------
interface gctb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [8:0]  knot_index;
  logic [15:0] knot_x;
  logic [15:0] knot_y;
  logic [11:0] pixel;

  modport source(output valid, opcode, knot_index, knot_x, knot_y, pixel, input ready);
  modport sink(input valid, opcode, knot_index, knot_x, knot_y, pixel, output ready);
endinterface

interface gctb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] gamma_value;
  logic       table_ready;

  modport source(output valid, gamma_value, table_ready, input ready);
  modport sink(input valid, gamma_value, table_ready, output ready);
endinterface

[rtl/gamma_curve_table_builder.sv]
// ----------------------------------------------------------------------------
// gamma_curve_table_builder
// Piecewise linear gamma table: knot loads, table build and pixel lookups.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | opcode, knot_index, knot_x, knot_y, pixel
//  out_ch   | out | valid/ready      | gamma_value, table_ready
//
//  with an empty queue and a free output a lookup result is valid once the
//  request has passed the queue, the registered table read and the output
//  register, later under a queue backlog or output stalls.
//  reset is synchronous; the table reads as zero until the first build, so
//  no clearing pass follows reset.
//  a four-deep request queue keeps taking requests, until it is full, while
//  a build or a stalled output holds the back part.
module gamma_curve_table_builder #(
  parameter int LINEAR_MAX = gctb_pkg::LINEAR_MAX_DEF
) (
  input logic        clk,
  input logic        rst_n,
  gctb_in_if.sink    in_ch,
  gctb_out_if.source out_ch
);

  gctb_pkg::cmdq_head_t head;
  logic                 pop;

  gctb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .head(head), .pop(pop)
  );

  gctb_back #(.LINEAR_MAX(LINEAR_MAX)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .out_ch(out_ch)
  );

endmodule

[rtl/gctb_ram.sv]
// ----------------------------------------------------------------------------
// gctb_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module gctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/gctb_div.sv]
// ----------------------------------------------------------------------------
// gctb_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gctb_div #(
  parameter int NW = 44
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] den_r, den_nxt;
  logic [NW:0]   trial;
  logic          ge;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r[NW-1:0], acc_r[NW-1]};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      rem_nxt  = '0;
      acc_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
      acc_nxt = {acc_r[NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = acc_r;

  // a new division never lands on one in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");

  // done follows the last step of a running division
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("divider done without a division");

  // the quotient is final once done shows
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

[rtl/gctb_front.sv]
// ----------------------------------------------------------------------------
// gctb_front
// Accepts requests, drops ignored ones and queues the rest for the back part.
// ----------------------------------------------------------------------------
module gctb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  gctb_in_if.sink              in_ch,
  output gctb_pkg::cmdq_head_t head,
  input  logic                 pop
);

  localparam int CNTW = $clog2(gctb_pkg::CMDQ_DEPTH + 1);

  gctb_pkg::cmd_t                  q_mem [gctb_pkg::CMDQ_DEPTH];
  logic [gctb_pkg::CMDQ_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [gctb_pkg::CMDQ_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]                 cnt_r, cnt_nxt;
  logic                            legal;
  logic                            push;
  gctb_pkg::cmd_t                  cmd_in;

  // classify the incoming request
  always_comb begin
    case (in_ch.opcode)
      gctb_pkg::OP_LOAD:   legal = (in_ch.knot_index <= gctb_pkg::LAST_KNOT);
      gctb_pkg::OP_BUILD:  legal = 1'b1;
      gctb_pkg::OP_LOOKUP: legal = 1'b1;
      default:             legal = 1'b0;
    endcase
  end

  assign in_ch.ready  = (cnt_r != CNTW'(gctb_pkg::CMDQ_DEPTH));
  assign push         = in_ch.valid && in_ch.ready && legal;
  assign cmd_in.op    = gctb_pkg::op_e'(in_ch.opcode);
  assign cmd_in.idx   = in_ch.knot_index;
  assign cmd_in.x     = in_ch.knot_x;
  assign cmd_in.y     = in_ch.knot_y;
  assign cmd_in.pixel = in_ch.pixel;

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_mem[rd_ptr_r];

  // back part only pops what is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
    else $error("pop from empty request queue");

  // fill level stays within the queue
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r <= CNTW'(gctb_pkg::CMDQ_DEPTH))
    else $error("request queue overflow");

  // an ignored opcode leaves the queue level unchanged
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
      (in_ch.valid && in_ch.ready && !legal && !pop) |=> cnt_r == $past(cnt_r))
    else $error("ignored request entered the queue");

endmodule

[rtl/gctb_back.sv]
// ----------------------------------------------------------------------------
// gctb_back
// Executes queued requests: knot writes, table build and pixel lookups.
// ----------------------------------------------------------------------------
module gctb_back #(
  parameter int LINEAR_MAX = gctb_pkg::LINEAR_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gctb_pkg::cmdq_head_t head,
  output logic                 pop,
  gctb_out_if.source           out_ch
);

  localparam int TW = $clog2(LINEAR_MAX + 1);
  localparam int NW = TW + 32;
  localparam int PW = TW + 16;
  localparam int YW = 24;
  localparam logic [NW-1:0] LM_N = NW'(LINEAR_MAX);
  localparam logic [TW-1:0] LM_T = TW'(LINEAR_MAX);
  localparam logic [7:0]    TOP  = 8'(gctb_pkg::GAMMA_TOP);

  gctb_pkg::back_state_e state_r, state_nxt;

  logic [gctb_pkg::KNOT_AW-1:0] k_r, k_nxt;
  logic [15:0]   xmax_r, xmax_nxt, ymax_r, ymax_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [NW-1:0] nx0_r, nx0_nxt, nx1_r, nx1_nxt;
  logic [YW-1:0] ny0_r, ny0_nxt, ny1_r, ny1_nxt;
  logic [TW:0]   i_r, i_nxt;
  logic [TW-1:0] last_r, last_nxt;
  logic [16:0]   w_r, w_nxt;
  logic signed [42:0] mul_r, mul_nxt;
  logic          ready_r, ready_nxt, built_r, built_nxt;
  logic          pend_r, pend_nxt, pend_built_r, pend_built_nxt;
  logic          pend_rdy_r, pend_rdy_nxt;
  logic          ov_r, ov_nxt, orf_r, orf_nxt;
  logic [7:0]    og_r, og_nxt;

  // memory and divider hookup
  logic                         kwe, kre, gwe, gre;
  logic [gctb_pkg::KNOT_AW-1:0] kraddr;
  logic [15:0]                  kx_q, ky_q;
  logic [TW-1:0]                gwaddr, graddr;
  logic [7:0]                   gwdata, gq;
  logic                         div_start, div_done;
  logic [NW-1:0]                div_num, div_den, div_quo;

  // helpers
  logic          out_free, issue_ok;
  logic [15:0]   ymax_cmp;
  logic [NW:0]   first_full;
  logic [NW-1:0] num_w;
  logic signed [24:0] dy;
  logic signed [17:0] ws;
  logic signed [43:0] v;
  logic [43:0]   v_rnd;
  logic [24:0]   zw_rnd;
  logic [7:0]    res_zw, res_ip;

  gctb_ram #(.WIDTH(16), .DEPTH(gctb_pkg::KNOTS)) u_knot_x (
    .clk(clk), .we(kwe), .waddr(head.cmd.idx), .wdata(head.cmd.x),
    .re(kre), .raddr(kraddr), .rdata(kx_q)
  );

  gctb_ram #(.WIDTH(16), .DEPTH(gctb_pkg::KNOTS)) u_knot_y (
    .clk(clk), .we(kwe), .waddr(head.cmd.idx), .wdata(head.cmd.y),
    .re(kre), .raddr(kraddr), .rdata(ky_q)
  );

  gctb_ram #(.WIDTH(8), .DEPTH(LINEAR_MAX + 1)) u_table (
    .clk(clk), .we(gwe), .waddr(gwaddr), .wdata(gwdata),
    .re(gre), .raddr(graddr), .rdata(gq)
  );

  gctb_div #(.NW(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // datapath terms
  always_comb begin
    out_free   = !ov_r || out_ch.ready;
    issue_ok   = !pend_r || out_free;
    ymax_cmp   = (ky_q > ymax_r) ? ky_q : ymax_r;
    first_full = {1'b0, nx0_r} + (NW + 1)'(16'hFFFF);
    num_w      = {{(NW - TW - 17){1'b0}}, i_r, 16'h0000} - nx0_r;
    dy         = $signed({1'b0, ny1_r}) - $signed({1'b0, ny0_r});
    ws         = $signed({1'b0, w_r});
    v          = $signed({4'b0000, ny0_r, 16'h0000}) + 44'(mul_r);
    v_rnd      = v[43] ? 44'h0 : (44'(v) + 44'h0_8000_0000);
    res_ip     = (v_rnd[43:32] > 12'(TOP)) ? TOP : v_rnd[39:32];
    zw_rnd     = {1'b0, ny0_r} + 25'h8000;
    res_zw     = (zw_rnd[24:16] > 9'(TOP)) ? TOP : zw_rnd[23:16];
    graddr     = (32'(head.cmd.pixel) > 32'(LINEAR_MAX)) ? LM_T : TW'(head.cmd.pixel);
  end

  // sequencer: next state and memory strobes
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    xmax_nxt       = xmax_r;
    ymax_nxt       = ymax_r;
    prod_nxt       = prod_r;
    nx0_nxt        = nx0_r;
    nx1_nxt        = nx1_r;
    ny0_nxt        = ny0_r;
    ny1_nxt        = ny1_r;
    i_nxt          = i_r;
    last_nxt       = last_r;
    w_nxt          = w_r;
    mul_nxt        = mul_r;
    ready_nxt      = ready_r;
    built_nxt      = built_r;
    pend_built_nxt = pend_built_r;
    pend_rdy_nxt   = pend_rdy_r;
    pop            = 1'b0;
    kwe            = 1'b0;
    kre            = 1'b0;
    kraddr         = k_r;
    gwe            = 1'b0;
    gwaddr         = i_r[TW-1:0];
    gwdata         = 8'h00;
    gre            = 1'b0;
    div_start      = 1'b0;
    div_num        = {prod_r, 16'h0000};
    div_den        = NW'(xmax_r);

    case (state_r)
      gctb_pkg::ST_IDLE: begin
        if (head.valid) begin
          case (head.cmd.op)
            gctb_pkg::OP_LOAD: begin
              pop       = 1'b1;
              kwe       = 1'b1;
              ready_nxt = 1'b0;
            end
            gctb_pkg::OP_BUILD: begin
              pop       = 1'b1;
              i_nxt     = '0;
              ymax_nxt  = '0;
              state_nxt = gctb_pkg::ST_CLEAR;
            end
            gctb_pkg::OP_LOOKUP: begin
              if (issue_ok) begin
                pop            = 1'b1;
                gre            = 1'b1;
                pend_built_nxt = built_r;
                pend_rdy_nxt   = ready_r;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      // sweep zeros through the table
      gctb_pkg::ST_CLEAR: begin
        gwe   = 1'b1;
        i_nxt = i_r + 1'b1;
        if (i_r[TW-1:0] == LM_T) begin
          kre       = 1'b1;
          kraddr    = '0;
          k_nxt     = '0;
          state_nxt = gctb_pkg::ST_YMAX;
        end
      end
      // largest y over all knots, last x
      gctb_pkg::ST_YMAX: begin
        ymax_nxt = ymax_cmp;
        if (k_r == gctb_pkg::LAST_KNOT) begin
          xmax_nxt = kx_q;
          if (kx_q == 16'h0 || ymax_cmp == 16'h0) begin
            ready_nxt = 1'b1;
            built_nxt = 1'b1;
            state_nxt = gctb_pkg::ST_IDLE;
          end else begin
            kre       = 1'b1;
            kraddr    = '0;
            k_nxt     = '0;
            state_nxt = gctb_pkg::ST_MULX;
          end
        end else begin
          kre    = 1'b1;
          kraddr = k_r + 1'b1;
          k_nxt  = k_r + 1'b1;
        end
      end
      // scale x of knot k
      gctb_pkg::ST_MULX: begin
        prod_nxt  = PW'(kx_q) * PW'(LINEAR_MAX);
        state_nxt = gctb_pkg::ST_STX;
      end
      gctb_pkg::ST_STX: begin
        div_start = 1'b1;
        state_nxt = gctb_pkg::ST_DIVX;
      end
      gctb_pkg::ST_DIVX: begin
        if (div_done) begin
          nx1_nxt   = div_quo;
          state_nxt = gctb_pkg::ST_MULY;
        end
      end
      // scale y of knot k
      gctb_pkg::ST_MULY: begin
        prod_nxt  = PW'(ky_q) * PW'(gctb_pkg::GAMMA_TOP);
        state_nxt = gctb_pkg::ST_STY;
      end
      gctb_pkg::ST_STY: begin
        div_start = 1'b1;
        div_den   = NW'(ymax_r);
        state_nxt = gctb_pkg::ST_DIVY;
      end
      gctb_pkg::ST_DIVY: begin
        if (div_done) begin
          ny1_nxt   = div_quo[YW-1:0];
          state_nxt = gctb_pkg::ST_SEGSET;
        end
      end
      // segment bounds, or shift in the first knot
      gctb_pkg::ST_SEGSET: begin
        if (k_r == '0) begin
          nx0_nxt   = nx1_r;
          ny0_nxt   = ny1_r;
          kre       = 1'b1;
          kraddr    = k_r + 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = gctb_pkg::ST_MULX;
        end else begin
          i_nxt     = (first_full[NW:16] > (NW - 15)'(LINEAR_MAX)) ?
                      (TW + 1)'(LINEAR_MAX + 1) : first_full[TW+16:16];
          last_nxt  = (nx1_r[NW-1:16] > LM_N[NW-17:0]) ? LM_T : nx1_r[TW+15:16];
          state_nxt = gctb_pkg::ST_PIX;
        end
      end
      // walk whole inputs of the segment
      gctb_pkg::ST_PIX: begin
        if (i_r > {1'b0, last_r}) begin
          nx0_nxt = nx1_r;
          ny0_nxt = ny1_r;
          if (k_r == gctb_pkg::LAST_KNOT) begin
            ready_nxt = 1'b1;
            built_nxt = 1'b1;
            state_nxt = gctb_pkg::ST_IDLE;
          end else begin
            kre       = 1'b1;
            kraddr    = k_r + 1'b1;
            k_nxt     = k_r + 1'b1;
            state_nxt = gctb_pkg::ST_MULX;
          end
        end else if (nx1_r == nx0_r) begin
          gwe    = 1'b1;
          gwdata = res_zw;
          i_nxt  = i_r + 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = {num_w[NW-17:0], 16'h0000};
          div_den   = nx1_r - nx0_r;
          state_nxt = gctb_pkg::ST_WDIV;
        end
      end
      gctb_pkg::ST_WDIV: begin
        if (div_done) begin
          w_nxt     = div_quo[16:0];
          state_nxt = gctb_pkg::ST_WMUL;
        end
      end
      gctb_pkg::ST_WMUL: begin
        mul_nxt   = dy * ws;
        state_nxt = gctb_pkg::ST_WADD;
      end
      gctb_pkg::ST_WADD: begin
        gwe       = 1'b1;
        gwdata    = res_ip;
        i_nxt     = i_r + 1'b1;
        state_nxt = gctb_pkg::ST_PIX;
      end
      default: state_nxt = gctb_pkg::ST_IDLE;
    endcase
  end

  // lookup read in flight and output register
  always_comb begin
    pend_nxt = pend_r;
    ov_nxt   = ov_r;
    og_nxt   = og_r;
    orf_nxt  = orf_r;
    if (pend_r && out_free) begin
      ov_nxt   = 1'b1;
      og_nxt   = pend_built_r ? gq : 8'h00;
      orf_nxt  = pend_rdy_r;
      pend_nxt = 1'b0;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (gre) begin
      pend_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gctb_pkg::ST_IDLE;
      ready_r <= 1'b0;
      built_r <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      built_r <= built_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    xmax_r       <= xmax_nxt;
    ymax_r       <= ymax_nxt;
    prod_r       <= prod_nxt;
    nx0_r        <= nx0_nxt;
    nx1_r        <= nx1_nxt;
    ny0_r        <= ny0_nxt;
    ny1_r        <= ny1_nxt;
    i_r          <= i_nxt;
    last_r       <= last_nxt;
    w_r          <= w_nxt;
    mul_r        <= mul_nxt;
    pend_built_r <= pend_built_nxt;
    pend_rdy_r   <= pend_rdy_nxt;
    og_r         <= og_nxt;
    orf_r        <= orf_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.gamma_value = og_r;
  assign out_ch.table_ready = orf_r;

  // a knot write always drops the ready flag
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n) kwe |=> !ready_r)
    else $error("ready flag survived a knot load");

  // a stalled lookup keeps its captured status
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (pend_r && !out_free) |=> (pend_r && $stable(pend_built_r) && $stable(pend_rdy_r)))
    else $error("pending lookup lost while output stalled");

  // a build never returns to idle without marking the table ready
  a_build_done: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r != gctb_pkg::ST_IDLE && state_nxt == gctb_pkg::ST_IDLE) |=>
      (ready_r && built_r))
    else $error("build ended without ready flag");

  // table writes happen only inside a build
  a_write_in_build: assert property (@(posedge clk) disable iff (!rst_n)
      gwe |-> (state_r == gctb_pkg::ST_CLEAR || state_r == gctb_pkg::ST_PIX ||
               state_r == gctb_pkg::ST_WADD))
    else $error("table written outside a build");

endmodule
